[rtl/itep_pkg.sv]
// Package for the timestamp-to-epoch converter: state and status codes,
// controller/datapath command and status structs, constants and the day table.
// No dependencies.
`default_nettype none

package itep_pkg;

    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 72;

    localparam logic [4:0] TS_LEN    = 5'd30;
    localparam logic [4:0] POS_LIMIT = 5'd31;

    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_Z     = 8'h5A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [13:0] YEAR_BIAS    = 14'd400;
    localparam logic [20:0] RECIP_25     = 21'd1311;
    localparam logic signed [23:0] DAYS_PER_ERA = 24'sd146097;
    localparam logic signed [23:0] EPOCH_SHIFT  = 24'sd719468;
    localparam logic signed [39:0] SECS_PER_DAY = 40'sd86400;
    localparam logic signed [30:0] NS_PER_S     = 31'sd1000000000;

    localparam logic signed [39:0] SECS_MAX  = 40'sd9223372036;
    localparam logic signed [39:0] SECS_MIN  = -40'sd9223372037;
    localparam logic [29:0]        FRAC_MAX  = 30'd854775807;
    localparam logic [29:0]        FRAC_MIN  = 30'd145224192;

    typedef enum logic [2:0] {
        STS_OK        = 3'd0,
        STS_LENGTH    = 3'd1,
        STS_SEPARATOR = 3'd2,
        STS_DIGIT     = 3'd3,
        STS_RANGE     = 3'd4
    } itep_status_t;

    typedef enum logic [3:0] {
        ST_COLLECT,
        ST_CHECK,
        ST_YEAR,
        ST_ERA,
        ST_DOE,
        ST_DAYS,
        ST_SECS,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SUM,
        ST_EMIT
    } itep_state_t;

    typedef struct packed {
        logic accept;
        logic capture;
        logic step_year;
        logic step_era;
        logic step_doe;
        logic step_days;
        logic step_secs;
        logic step_lo;
        logic step_hi;
        logic step_sum;
        logic load_out;
    } itep_cmd_t;

    typedef struct packed {
        logic status_ok;
    } itep_stat_t;

    // Day of the year at which each March-based month starts.
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] days;
        unique case (mp)
            4'd0:    days = 9'd0;
            4'd1:    days = 9'd31;
            4'd2:    days = 9'd61;
            4'd3:    days = 9'd92;
            4'd4:    days = 9'd122;
            4'd5:    days = 9'd153;
            4'd6:    days = 9'd184;
            4'd7:    days = 9'd214;
            4'd8:    days = 9'd245;
            4'd9:    days = 9'd275;
            4'd10:   days = 9'd306;
            4'd11:   days = 9'd337;
            default: days = 9'd0;
        endcase
        return days;
    endfunction

endpackage

`default_nettype wire

[rtl/itep_ctrl.sv]
// Controller of the timestamp converter: sequences byte collection, the
// status check, the conversion steps and the output register handshake. Uses itep_pkg.
`default_nettype none

module itep_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    input  wire logic              s_tlast,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    input  wire itep_pkg::itep_stat_t stat,
    output itep_pkg::itep_cmd_t    cmd
);
    import itep_pkg::*;

    itep_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_COLLECT;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_COLLECT: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid && s_tlast) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                cmd.capture = 1'b1;
                state_next  = stat.status_ok ? ST_YEAR : ST_EMIT;
            end
            ST_YEAR: begin
                cmd.step_year = 1'b1;
                state_next    = ST_ERA;
            end
            ST_ERA: begin
                cmd.step_era = 1'b1;
                state_next   = ST_DOE;
            end
            ST_DOE: begin
                cmd.step_doe = 1'b1;
                state_next   = ST_DAYS;
            end
            ST_DAYS: begin
                cmd.step_days = 1'b1;
                state_next    = ST_SECS;
            end
            ST_SECS: begin
                cmd.step_secs = 1'b1;
                state_next    = ST_MUL_LO;
            end
            ST_MUL_LO: begin
                cmd.step_lo = 1'b1;
                state_next  = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                cmd.step_hi = 1'b1;
                state_next  = ST_SUM;
            end
            ST_SUM: begin
                cmd.step_sum = 1'b1;
                state_next   = ST_EMIT;
            end
            ST_EMIT: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_COLLECT;
                end
            end
            default: state_next = ST_COLLECT;
        endcase
    end

    always_comb begin
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

`default_nettype wire

[rtl/itep_dpath.sv]
// Datapath of the timestamp converter: field accumulators, fault flags,
// the staged days-from-civil and nanosecond arithmetic, and the output register. Uses itep_pkg.
`default_nettype none

module itep_dpath (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic [itep_pkg::S_DATA_W-1:0] char_byte,
    input  wire itep_pkg::itep_cmd_t cmd,
    output itep_pkg::itep_stat_t     stat,
    output logic [itep_pkg::M_DATA_W-1:0] m_tdata
);
    import itep_pkg::*;

    logic [4:0]  pos_reg, pos_next;
    logic [13:0] year_reg, year_next;
    logic [6:0]  month_reg, month_next;
    logic [6:0]  day_reg, day_next;
    logic [6:0]  hour_reg, hour_next;
    logic [6:0]  minute_reg, minute_next;
    logic [6:0]  second_reg, second_next;
    logic [29:0] frac_reg, frac_next;
    logic        sep_fault_reg, sep_fault_next;
    logic        digit_fault_reg, digit_fault_next;

    logic        is_sep, is_digit, examine, wr_digit;
    logic [7:0]  sep_char;
    logic [3:0]  dig;

    itep_status_t status_now, status_reg;
    logic         range_bad;

    logic               m_le2;
    logic [13:0]        yp_next, yp_reg;
    logic [20:0]        qprod;
    logic [4:0]         q_reg;
    logic [3:0]         mp;
    logic [8:0]         doy_next, doy_reg;
    logic [8:0]         yoe_next, yoe_reg;
    logic signed [5:0]  era_next, era_reg;
    logic [6:0]         yoe_q;
    logic [17:0]        cprod;
    logic [17:0]        doe_next, doe_reg;
    logic signed [23:0] era_mul_next, era_mul_reg;
    logic signed [23:0] days_next, days_reg;
    logic [16:0]        tod;
    logic signed [39:0] secs_next, secs_reg;
    logic signed [20:0] mul_opd;
    logic signed [51:0] mul_prod;
    logic [63:0]        lo_next, lo_reg;
    logic [43:0]        hi_reg;
    logic [63:0]        nanos_reg;
    logic               ovf_next, ovf_reg;

    logic [2:0]         out_status_reg;
    logic [63:0]        out_nanos_reg;
    logic               out_ovf_reg;

    always_comb begin
        is_sep   = 1'b0;
        sep_char = CH_ZERO;
        case (pos_reg) inside
            5'd4, 5'd7: begin
                is_sep   = 1'b1;
                sep_char = CH_DASH;
            end
            5'd10: begin
                is_sep   = 1'b1;
                sep_char = CH_T;
            end
            5'd13, 5'd16: begin
                is_sep   = 1'b1;
                sep_char = CH_COLON;
            end
            5'd19: begin
                is_sep   = 1'b1;
                sep_char = CH_DOT;
            end
            5'd29: begin
                is_sep   = 1'b1;
                sep_char = CH_Z;
            end
            default: is_sep = 1'b0;
        endcase
    end

    assign is_digit = (char_byte >= CH_ZERO) && (char_byte <= CH_NINE);
    assign dig      = 4'(char_byte - CH_ZERO);
    assign examine  = cmd.accept && (pos_reg < TS_LEN);
    assign wr_digit = examine && !is_sep && is_digit;

    always_comb begin
        year_next        = year_reg;
        month_next       = month_reg;
        day_next         = day_reg;
        hour_next        = hour_reg;
        minute_next      = minute_reg;
        second_next      = second_reg;
        frac_next        = frac_reg;
        pos_next         = pos_reg;
        sep_fault_next   = sep_fault_reg | (examine && is_sep && (char_byte != sep_char));
        digit_fault_next = digit_fault_reg | (examine && !is_sep && !is_digit);
        if (cmd.accept) begin
            pos_next = (pos_reg == POS_LIMIT) ? POS_LIMIT : pos_reg + 5'd1;
        end
        if (wr_digit) begin
            if (pos_reg < 5'd4) begin
                year_next = 14'(year_reg * 14'd10 + 14'(dig));
            end else if (pos_reg < 5'd7) begin
                month_next = 7'(month_reg * 7'd10 + 7'(dig));
            end else if (pos_reg < 5'd10) begin
                day_next = 7'(day_reg * 7'd10 + 7'(dig));
            end else if (pos_reg < 5'd13) begin
                hour_next = 7'(hour_reg * 7'd10 + 7'(dig));
            end else if (pos_reg < 5'd16) begin
                minute_next = 7'(minute_reg * 7'd10 + 7'(dig));
            end else if (pos_reg < 5'd19) begin
                second_next = 7'(second_reg * 7'd10 + 7'(dig));
            end else begin
                frac_next = 30'(frac_reg * 30'd10 + 30'(dig));
            end
        end
        if (cmd.load_out) begin
            year_next        = '0;
            month_next       = '0;
            day_next         = '0;
            hour_next        = '0;
            minute_next      = '0;
            second_next      = '0;
            frac_next        = '0;
            pos_next         = '0;
            sep_fault_next   = 1'b0;
            digit_fault_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg         <= '0;
            year_reg        <= '0;
            month_reg       <= '0;
            day_reg         <= '0;
            hour_reg        <= '0;
            minute_reg      <= '0;
            second_reg      <= '0;
            frac_reg        <= '0;
            sep_fault_reg   <= 1'b0;
            digit_fault_reg <= 1'b0;
        end else begin
            pos_reg         <= pos_next;
            year_reg        <= year_next;
            month_reg       <= month_next;
            day_reg         <= day_next;
            hour_reg        <= hour_next;
            minute_reg      <= minute_next;
            second_reg      <= second_next;
            frac_reg        <= frac_next;
            sep_fault_reg   <= sep_fault_next;
            digit_fault_reg <= digit_fault_next;
        end
    end

    assign range_bad = (month_reg < 7'd1) || (month_reg > 7'd12) || (day_reg < 7'd1) ||
                       (day_reg > 7'd31) || (hour_reg > 7'd23) || (minute_reg > 7'd59) ||
                       (second_reg > 7'd60);

    always_comb begin
        if (pos_reg != TS_LEN) begin
            status_now = STS_LENGTH;
        end else if (sep_fault_reg) begin
            status_now = STS_SEPARATOR;
        end else if (digit_fault_reg) begin
            status_now = STS_DIGIT;
        end else if (range_bad) begin
            status_now = STS_RANGE;
        end else begin
            status_now = STS_OK;
        end
    end

    assign stat.status_ok = (status_now == STS_OK);

    // The year is biased by one era so that the era split works on unsigned values.
    assign m_le2    = (month_reg <= 7'd2);
    assign yp_next  = 14'(year_reg + YEAR_BIAS - {13'd0, m_le2});
    assign qprod    = 21'(yp_next[13:4]) * RECIP_25;
    assign mp       = m_le2 ? 4'(month_reg + 7'd9) : 4'(month_reg - 7'd3);
    assign doy_next = 9'(month_start(mp) + 9'(day_reg) - 9'd1);

    assign yoe_next = 9'(yp_reg - 14'(q_reg) * YEAR_BIAS);
    assign era_next = $signed({1'b0, q_reg}) - 6'sd1;

    assign yoe_q        = yoe_reg[8:2];
    assign cprod        = 18'(yoe_q) * 18'(RECIP_25);
    assign doe_next     = 18'(yoe_reg) * 18'd365 + 18'(yoe_q) - 18'(cprod[17:15])
                          + 18'(doy_reg);
    assign era_mul_next = 24'(era_reg) * DAYS_PER_ERA;

    assign days_next = era_mul_reg + $signed({6'd0, doe_reg}) - EPOCH_SHIFT;

    assign tod       = 17'(hour_reg) * 17'd3600 + 17'(minute_reg) * 17'd60 + 17'(second_reg);
    assign secs_next = 40'(days_reg) * SECS_PER_DAY + $signed({23'd0, tod});

    assign mul_opd  = cmd.step_hi ? {secs_reg[39], secs_reg[39:20]} : {1'b0, secs_reg[19:0]};
    assign mul_prod = mul_opd * NS_PER_S;
    assign lo_next  = 64'(mul_prod[49:0]) + 64'(frac_reg);
    assign ovf_next = (secs_reg > SECS_MAX) || ((secs_reg == SECS_MAX) && (frac_reg > FRAC_MAX))
                      || (secs_reg < SECS_MIN)
                      || ((secs_reg == SECS_MIN) && (frac_reg < FRAC_MIN));

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            status_reg <= status_now;
        end
        if (cmd.step_year) begin
            yp_reg  <= yp_next;
            q_reg   <= qprod[19:15];
            doy_reg <= doy_next;
        end
        if (cmd.step_era) begin
            yoe_reg <= yoe_next;
            era_reg <= era_next;
        end
        if (cmd.step_doe) begin
            doe_reg     <= doe_next;
            era_mul_reg <= era_mul_next;
        end
        if (cmd.step_days) begin
            days_reg <= days_next;
        end
        if (cmd.step_secs) begin
            secs_reg <= secs_next;
        end
        if (cmd.step_lo) begin
            lo_reg  <= lo_next;
            ovf_reg <= ovf_next;
        end
        if (cmd.step_hi) begin
            hi_reg <= mul_prod[43:0];
        end
        if (cmd.step_sum) begin
            nanos_reg <= {hi_reg, 20'd0} + lo_reg;
        end
        if (cmd.load_out) begin
            out_status_reg <= status_reg;
            if (status_reg == STS_OK) begin
                out_nanos_reg <= nanos_reg;
                out_ovf_reg   <= ovf_reg;
            end else begin
                out_nanos_reg <= '0;
                out_ovf_reg   <= 1'b0;
            end
        end
    end

    assign m_tdata = {4'd0, out_ovf_reg, out_nanos_reg, out_status_reg};

endmodule

`default_nettype wire

[rtl/iso_timestamp_to_epoch_nanos.sv]
// Top level of the ISO timestamp to epoch nanoseconds converter.
// Instantiates itep_ctrl and itep_dpath; uses itep_pkg.
`default_nettype none

// Bytes of one timestamp string are taken one per cycle, the last one marked
// by s_tlast. After the last byte the input stalls while the result is formed:
// a rejected string passes only the check and emit states, a valid timestamp
// also the days-from-civil steps and the two halves of the seconds-to-
// nanoseconds product on one shared multiplier. The emit state also waits
// while the previous result word is still held. One result word per
// string leaves through an output register, so the next string is collected
// while it waits.
module iso_timestamp_to_epoch_nanos (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [itep_pkg::S_DATA_W-1:0]   s_tdata,   // [7:0] char_byte
    input  wire logic                            s_tlast,   // end_of_text
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [itep_pkg::M_DATA_W-1:0]        m_tdata    // [2:0] status, [66:3] epoch_nanos, [67] overflow
);
    import itep_pkg::*;

    itep_cmd_t  cmd;
    itep_stat_t stat;

    itep_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    itep_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .char_byte (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

[rtl/itep_checker.sv]
// Port-level checker for iso_timestamp_to_epoch_nanos and its bind statement.
// Uses itep_pkg for the status codes and the word width.
`default_nettype none

module itep_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        s_tlast,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [itep_pkg::M_DATA_W-1:0] m_tdata
);
    import itep_pkg::*;

    a_no_word_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word valid right after reset");

    a_stall_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input not stalled after the last byte");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2:0] <= STS_RANGE))
        else $error("undefined status code");

    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2:0] != STS_OK) |-> (m_tdata[71:3] == 69'd0))
        else $error("error result carries nonzero payload");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result word changed");

endmodule

bind iso_timestamp_to_epoch_nanos itep_checker u_itep_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
